// File: rtl/core/utf8s_pkg.sv
`timescale 1ns / 1ps

package utf8s_pkg;

	localparam logic [7:0] REPL_BYTE = 8'h3F;
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned HELD_DEPTH = 3;

	typedef logic [7:0] byte_t;

	// pending partial sequence: lead byte first
	typedef struct packed {
		byte_t [HELD_DEPTH-1:0] bytes;
		logic [1:0] count;
	} held_t;

	// up to four result bytes caused by one request
	typedef struct packed {
		byte_t [MAX_RESULTS-1:0] bytes;
		logic [2:0] n;
	} step_res_t;

	// total sequence length started by b, 0 when b cannot lead
	function automatic logic [2:0] seq_len(input byte_t b);
		logic [2:0] len;
		if (b[7] == 1'b0) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage

// File: rtl/core/utf8s_step.sv
`timescale 1ns / 1ps

module utf8s_step import utf8s_pkg::*; (
	input  held_t     held,
	input  byte_t     in_byte,
	input  logic      in_final,
	output step_res_t res,
	output held_t     held_nxt
);

	logic [2:0] need;
	logic [2:0] hc_ext;
	logic       is_cont;
	logic       fresh;
	logic       surr;
	logic [2:0] len;
	logic [2:0] na;
	logic       nb;
	logic [1:0] nc;
	byte_t      fb;
	byte_t [MAX_RESULTS-1:0] a;
	logic [2:0] nab;

	always_comb begin
		need     = seq_len(held.bytes[0]);
		hc_ext   = {1'b0, held.count};
		is_cont  = (in_byte[7:6] == 2'b10);
		len      = seq_len(in_byte);
		// code point D800..DFFF: low nibble of lead is D and top payload bit of second is set
		surr     = (need == 3'd3) && (held.bytes[0][3:0] == 4'hD) && held.bytes[1][5];
		held_nxt = held;
		fresh    = 1'b1;
		na       = 3'd0;
		nb       = 1'b0;
		fb       = REPL_BYTE;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			a[k] = REPL_BYTE;
		end

		if (held.count != 2'd0) begin
			if (need < 3'd2 || hc_ext >= need || !is_cont) begin
				// broken sequence: held bytes become replacements
				na = hc_ext;
				held_nxt.count = 2'd0;
			end else begin
				fresh = 1'b0;
				if (hc_ext + 3'd1 == need) begin
					if (surr) begin
						na = 3'd3;
					end else begin
						na = need;
						for (int k = 0; k < HELD_DEPTH; k++) begin
							a[k] = (3'(k) < hc_ext) ? held.bytes[k] : in_byte;
						end
						a[MAX_RESULTS-1] = in_byte;
					end
					held_nxt.count = 2'd0;
				end else begin
					for (int k = 0; k < HELD_DEPTH; k++) begin
						if (2'(k) == held.count) begin
							held_nxt.bytes[k] = in_byte;
						end
					end
					held_nxt.count = held.count + 2'd1;
				end
			end
		end

		if (fresh) begin
			if (len == 3'd1) begin
				nb = 1'b1;
				fb = in_byte;
			end else if (len == 3'd0) begin
				nb = 1'b1;
				fb = REPL_BYTE;
			end else begin
				held_nxt.bytes[0] = in_byte;
				held_nxt.count    = 2'd1;
			end
		end

		// final byte flushes whatever is still pending
		nc = 2'd0;
		if (in_final) begin
			nc = held_nxt.count;
			held_nxt.count = 2'd0;
		end

		nab   = na + {2'b00, nb};
		res.n = nab + {1'b0, nc};
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (3'(k) < na) begin
				res.bytes[k] = a[k];
			end else if (3'(k) < nab) begin
				res.bytes[k] = fb;
			end else begin
				res.bytes[k] = REPL_BYTE;
			end
		end
	end

endmodule

// File: rtl/core/utf8_stream_sanitizer.sv
`timescale 1ns / 1ps
// a request is registered in the input stage, and its results load the output buffer
// once that buffer is free; results are offered from its bottom slot
// throughput: one request per cycle while each yields at most one result and the output is
// ready; a request yielding n results holds the next one while they drain through the
// single output byte lane
// reset: arst_n clears the pending sequence, the input valid flag and the output count

module utf8_stream_sanitizer import utf8s_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  byte_t in_byte,
	input  logic  in_final,
	output logic  out_valid,
	input  logic  out_ready,
	output byte_t out_byte,
	output logic  run_last,
	output logic  string_done
);

	logic      valid_s1;
	byte_t     byte_s1;
	logic      final_s1;
	held_t     held_q;
	held_t     held_nxt;
	step_res_t res;
	byte_t [MAX_RESULTS-1:0] obuf_q;
	logic [2:0] ocnt_q;
	logic       ofin_q;
	logic       pop;
	logic       buf_free;
	logic       process;

	utf8s_step u_step (
		.held     (held_q),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.res      (res),
		.held_nxt (held_nxt)
	);

	assign pop      = out_valid && out_ready;
	assign buf_free = (ocnt_q == 3'd0) || (ocnt_q == 3'd1 && out_ready);
	assign process  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || process;

	assign out_valid   = (ocnt_q != 3'd0);
	assign out_byte    = obuf_q[0];
	assign run_last    = (ocnt_q == 3'd1);
	assign string_done = (ocnt_q == 3'd1) && ofin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			final_s1 <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (process) begin
			held_q <= held_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 3'd0;
			ofin_q <= 1'b0;
		end else if (process) begin
			ocnt_q <= res.n;
			ofin_q <= final_s1;
		end else if (pop) begin
			ocnt_q <= ocnt_q - 3'd1;
		end
	end

	// results drain from the bottom slot, the rest shift down
	always_ff @(posedge clk) begin
		if (process) begin
			obuf_q <= res.bytes;
		end else if (pop) begin
			for (int k = 0; k < MAX_RESULTS - 1; k++) begin
				obuf_q[k] <= obuf_q[k+1];
			end
		end
	end

endmodule

// File: tb/tb_utf8_stream_sanitizer.sv
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;
	import utf8s_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 72;

	typedef struct packed {
		byte_t b;
		logic  run_last;
		logic  string_done;
	} san_out_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	byte_t in_byte = 8'h00;
	logic  in_final = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	byte_t out_byte;
	logic  run_last;
	logic  string_done;

	// predictor state: pending partial sequence
	byte_t    held_seq [3];
	int       held_cnt = 0;
	san_out_t step_q [$];
	san_out_t sanitized_q [$];
	byte_t    text_q [$];
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       err_count = 0;
	int       cycle_count = 0;

	utf8_stream_sanitizer dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		san_out_t want;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= stall_pct);
			if (out_valid && out_ready) begin
				if (sanitized_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result: expected none, got %h/%b/%b",
						$time, out_byte, run_last, string_done);
				end else begin
					want = sanitized_q.pop_front();
					if (out_byte !== want.b || run_last !== want.run_last ||
							string_done !== want.string_done) begin
						err_count++;
						$display("%0t: mismatch (byte/run_last/string_done): expected %h/%b/%b, got %h/%b/%b",
							$time, want.b, want.run_last, want.string_done,
							out_byte, run_last, string_done);
					end
				end
			end
		end
	end

	function automatic int lead_len(input byte_t b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic void emit_byte(input byte_t b);
		if (step_q.size() < MAX_RESULTS) begin
			step_q.push_back('{b, 1'b0, 1'b0});
		end
	endfunction

	function automatic void flush_held();
		repeat (held_cnt) emit_byte(REPL_BYTE);
		held_cnt = 0;
	endfunction

	function automatic void sanitize_byte(input byte_t b, input logic fin);
		int need;
		logic fresh;
		logic [15:0] cp;
		san_out_t tail;
		step_q.delete();
		fresh = 1'b1;
		if (held_cnt > 0) begin
			need = lead_len(held_seq[0]);
			if (need < 2 || held_cnt >= need) begin
				flush_held();
			end else if (b[7:6] == 2'b10) begin
				fresh = 1'b0;
				if (held_cnt + 1 == need) begin
					cp = {held_seq[0][3:0], held_seq[1][5:0], b[5:0]};
					// surrogate halves are not legal scalar values
					if (need == 3 && cp >= 16'hD800 && cp <= 16'hDFFF) begin
						repeat (3) emit_byte(REPL_BYTE);
					end else begin
						for (int i = 0; i < held_cnt; i++) emit_byte(held_seq[i]);
						emit_byte(b);
					end
					held_cnt = 0;
				end else begin
					held_seq[held_cnt] = b;
					held_cnt++;
				end
			end else begin
				// broken sequence, new byte starts over below
				flush_held();
			end
		end
		if (fresh) begin
			case (lead_len(b))
				0: emit_byte(REPL_BYTE);
				1: emit_byte(b);
				default: begin
					held_seq[0] = b;
					held_cnt = 1;
				end
			endcase
		end
		if (fin) flush_held();
		if (step_q.size() > 0) begin
			tail = step_q.pop_back();
			tail.run_last = 1'b1;
			tail.string_done = fin;
			step_q.push_back(tail);
		end
		foreach (step_q[i]) sanitized_q.push_back(step_q[i]);
	endfunction

	task automatic send_req(input byte_t b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_final <= fin;
		do @(posedge clk); while (!in_ready);
		sanitize_byte(b, fin);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sanitized_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic test_ascii();
		// zero byte is plain data
		send_req(8'h00, 1'b0);
		send_req(8'h7F, 1'b1);
	endtask

	task automatic test_well_formed();
		send_req(8'hC2, 1'b0);
		send_req(8'h80, 1'b0);
		send_req(8'hEF, 1'b0);
		send_req(8'hBF, 1'b0);
		send_req(8'hBF, 1'b0);
		send_req(8'hF0, 1'b0);
		send_req(8'h9F, 1'b0);
		send_req(8'h98, 1'b0);
		send_req(8'h80, 1'b1);
	endtask

	task automatic test_surrogate();
		send_req(8'hED, 1'b0);
		send_req(8'hA0, 1'b0);
		send_req(8'h80, 1'b1);
	endtask

	task automatic test_broken_sequence();
		// three held bytes plus a non-continuation gives four results
		send_req(8'hF4, 1'b0);
		send_req(8'h8F, 1'b0);
		send_req(8'hBF, 1'b0);
		send_req(8'h41, 1'b0);
		send_req(8'hE2, 1'b0);
		send_req(8'hC3, 1'b1);
	endtask

	task automatic test_invalid_bytes();
		send_req(8'h80, 1'b0);
		send_req(8'hBF, 1'b0);
		send_req(8'hF8, 1'b0);
		send_req(8'hFF, 1'b1);
	endtask

	task automatic test_final_flush();
		// final byte is a new lead while three bytes are pending
		send_req(8'hF0, 1'b0);
		send_req(8'h9F, 1'b0);
		send_req(8'h98, 1'b0);
		send_req(8'hE2, 1'b1);
		send_req(8'hDF, 1'b1);
	endtask

	task automatic add_cont(input int n);
		repeat (n) text_q.push_back({2'b10, 6'($urandom)});
	endtask

	task automatic add_random_char();
		int kind;
		int len;
		byte_t lead;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2: text_q.push_back(byte_t'($urandom_range(127)));
			3: begin
				text_q.push_back({3'b110, 5'($urandom)});
				add_cont(1);
			end
			4: begin
				text_q.push_back({4'b1110, 4'($urandom)});
				add_cont(2);
			end
			5: begin
				// surrogate half, or just below it
				text_q.push_back(8'hED);
				text_q.push_back({2'b10, 1'($urandom), 5'($urandom)});
				add_cont(1);
			end
			6: begin
				text_q.push_back({5'b11110, 3'($urandom)});
				add_cont(3);
			end
			7: begin
				// sequence cut short
				len = $urandom_range(4, 2);
				lead = byte_t'($urandom);
				case (len)
					2: lead[7:5] = 3'b110;
					3: lead[7:4] = 4'b1110;
					default: lead[7:3] = 5'b11110;
				endcase
				text_q.push_back(lead);
				add_cont($urandom_range(len - 2));
			end
			8: begin
				if ($urandom_range(1)) text_q.push_back(byte_t'($urandom_range(8'hBF, 8'h80)));
				else text_q.push_back(byte_t'($urandom_range(8'hFF, 8'hF8)));
			end
			default: text_q.push_back(byte_t'($urandom));
		endcase
	endtask

	task automatic test_random_strings(input int n_items, input int in_idle, input int out_stall);
		int sent;
		int n_chars;
		sent = 0;
		idle_pct = in_idle;
		stall_pct = out_stall;
		while (sent < n_items) begin
			text_q.delete();
			n_chars = $urandom_range(6, 1);
			repeat (n_chars) add_random_char();
			foreach (text_q[i]) send_req(text_q[i], i == text_q.size() - 1);
			sent += text_q.size();
			if ($urandom_range(14) == 0) wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii();
		test_well_formed();
		test_surrogate();
		test_broken_sequence();
		test_invalid_bytes();
		test_final_flush();
		wait_drain();
		test_random_strings(RANDOM_ITEMS, 0, 0);
		test_random_strings(RANDOM_ITEMS, 51, 0);
		test_random_strings(RANDOM_ITEMS, 0, 51);
		test_random_strings(RANDOM_ITEMS, 21, 21);
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/utf8s_pkg.sv
rtl/core/utf8s_step.sv
rtl/core/utf8_stream_sanitizer.sv
tb/tb_utf8_stream_sanitizer.sv
